FILE: design/hsfb_pkg.sv
// ----------------------------------------------------------------------------
// hsfb_pkg
// Shared types and constants for the half-screen fill/blit engine.
// ----------------------------------------------------------------------------
`default_nettype none

package hsfb_pkg;

  localparam int SCREEN_WIDTH = 128;
  localparam int HALF_HEIGHT  = 64;
  localparam int PIX_W        = 16;
  localparam int COORD_W      = 18;   // exact sums of two 16-bit signed values

  localparam logic [PIX_W-1:0] KEY_COLOR = 16'hFFFF;

  typedef enum logic [2:0] {
    OP_SET  = 3'd0,
    OP_FILL = 3'd1,
    OP_HDR  = 3'd2,
    OP_BPIX = 3'd3,
    OP_READ = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_MEM,
    S_FSET,
    S_FILL,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [2:0]        opcode;
    logic signed [15:0] x_pos;
    logic signed [15:0] y_pos;
    logic signed [15:0] width;
    logic signed [15:0] height;
    logic [PIX_W-1:0]  color;
    logic              keyed;
  } in_req_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_value;
    logic             inside_res;
  } out_rsp_t;

endpackage

`default_nettype wire

FILE: design/hsfb_ram.sv
// ----------------------------------------------------------------------------
// hsfb_ram
// Generic single-port RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hsfb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

FILE: design/hsfb_engine.sv
// ----------------------------------------------------------------------------
// hsfb_engine
// Command sequencer: clear sweep, pixel/blit address generation, fill walker.
// ----------------------------------------------------------------------------
`default_nettype none

module hsfb_engine #(
  parameter int SCREEN_WIDTH = hsfb_pkg::SCREEN_WIDTH,
  parameter int HALF_HEIGHT  = hsfb_pkg::HALF_HEIGHT
) (
  input  wire logic                                        clk,
  input  wire logic                                        rst_n,
  input  wire logic                                        half_sel,
  input  wire logic                                        in_valid,
  output logic                                             in_ready,
  input  wire hsfb_pkg::in_req_t                           in_req,
  output logic                                             mem_we,
  output logic                                             mem_re,
  output logic [$clog2(SCREEN_WIDTH*HALF_HEIGHT)-1:0]      mem_addr,
  output logic [hsfb_pkg::PIX_W-1:0]                       mem_wdata,
  input  wire logic [hsfb_pkg::PIX_W-1:0]                  mem_rdata,
  input  wire logic                                        rsp_free,
  output logic                                             rsp_load,
  output hsfb_pkg::out_rsp_t                               rsp
);

  localparam int DEPTH = SCREEN_WIDTH * HALF_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(SCREEN_WIDTH);
  localparam int RW    = $clog2(HALF_HEIGHT);
  localparam int COLW  = $clog2(SCREEN_WIDTH + 1);
  localparam int ROWW  = $clog2(2 * HALF_HEIGHT + 1);
  localparam int XW    = hsfb_pkg::COORD_W;

  localparam logic signed [XW-1:0] ZERO_S = '0;
  localparam logic signed [XW-1:0] ONE_S  = XW'(1);
  localparam logic signed [XW-1:0] SW_S   = XW'(SCREEN_WIDTH);
  localparam logic signed [XW-1:0] SWM1_S = XW'(SCREEN_WIDTH - 1);
  localparam logic signed [XW-1:0] HH_S   = XW'(HALF_HEIGHT);
  localparam logic signed [XW-1:0] H2_S   = XW'(2 * HALF_HEIGHT);

  hsfb_pkg::state_t  state_r, state_nxt;
  hsfb_pkg::in_req_t cmd_r;

  logic [AW-1:0]   clr_addr_r;
  logic            blit_open_r, blit_keyed_r;
  logic signed [15:0] blit_left_r, blit_bottom_r;
  logic [COLW-1:0] cols_r, src_col_r, src_col_inc;
  logic [ROWW-1:0] rows_r, src_row_r, src_row_inc;

  logic [CW-1:0]   pix_x_r;
  logic [RW-1:0]   pix_ro_r;
  logic            pix_wr_r;

  logic [CW-1:0]   cl_r, cr_r, col_r;
  logic [RW-1:0]   cto_r, cbo_r, rows_left_r, ro_lo;
  logic [AW-1:0]   rbase_r;

  // coordinate math
  logic signed [XW-1:0] first_s, last_s, x_s, y_s, w_s, h_s;
  logic signed [XW-1:0] sx_s, sy_s, px_s, py_s, ro_s;
  logic signed [XW-1:0] f_right, f_bot, cl_s, cr_s, ct_s, cb_s;
  logic                 in_win, key_skip, fill_ok, is_bpix;

  assign first_s = half_sel ? HH_S : ZERO_S;
  assign last_s  = first_s + HH_S - ONE_S;
  assign x_s     = XW'(cmd_r.x_pos);
  assign y_s     = XW'(cmd_r.y_pos);
  assign w_s     = XW'(cmd_r.width);
  assign h_s     = XW'(cmd_r.height);

  assign sx_s    = XW'(blit_left_r) + $signed(XW'(src_col_r));
  assign sy_s    = XW'(blit_bottom_r) - $signed(XW'(src_row_r));
  assign is_bpix = (cmd_r.opcode == hsfb_pkg::OP_BPIX);
  assign px_s    = is_bpix ? sx_s : x_s;
  assign py_s    = is_bpix ? sy_s : y_s;
  assign in_win  = (px_s >= ZERO_S) && (px_s < SW_S) && (py_s >= first_s) && (py_s <= last_s);
  assign ro_s    = last_s - py_s;
  assign key_skip = blit_keyed_r && (cmd_r.color == hsfb_pkg::KEY_COLOR);

  assign src_col_inc = COLW'(src_col_r + 1'b1);
  assign src_row_inc = ROWW'(src_row_r + 1'b1);

  // fill clipping
  assign f_right = x_s + w_s - ONE_S;
  assign f_bot   = y_s + h_s - ONE_S;
  assign fill_ok = (w_s >= ONE_S) && (w_s <= SW_S) && (h_s >= ONE_S) && (h_s <= H2_S) &&
                   (x_s <= SWM1_S) && (f_right >= ZERO_S) &&
                   (f_bot >= first_s) && (y_s <= last_s);
  assign cl_s    = (x_s < ZERO_S) ? ZERO_S : x_s;
  assign cr_s    = (f_right > SWM1_S) ? SWM1_S : f_right;
  assign ct_s    = ((y_s < first_s) ? first_s : y_s) - first_s;
  assign cb_s    = ((f_bot > last_s) ? last_s : f_bot) - first_s;
  assign ro_lo   = RW'(HALF_HEIGHT - 1) - cbo_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      hsfb_pkg::S_CLEAR: begin
        if (clr_addr_r == AW'(DEPTH - 1)) state_nxt = hsfb_pkg::S_IDLE;
      end
      hsfb_pkg::S_IDLE: begin
        if (in_valid) state_nxt = hsfb_pkg::S_EXEC;
      end
      hsfb_pkg::S_EXEC: begin
        case (cmd_r.opcode)
          hsfb_pkg::OP_SET:
            state_nxt = in_win ? hsfb_pkg::S_MEM : hsfb_pkg::S_IDLE;
          hsfb_pkg::OP_FILL:
            state_nxt = fill_ok ? hsfb_pkg::S_FSET : hsfb_pkg::S_IDLE;
          hsfb_pkg::OP_BPIX:
            state_nxt = (blit_open_r && in_win && !key_skip) ? hsfb_pkg::S_MEM
                                                             : hsfb_pkg::S_IDLE;
          hsfb_pkg::OP_READ: begin
            if (in_win) state_nxt = hsfb_pkg::S_MEM;
            else if (rsp_free) state_nxt = hsfb_pkg::S_IDLE;
          end
          default: state_nxt = hsfb_pkg::S_IDLE;
        endcase
      end
      hsfb_pkg::S_MEM: begin
        state_nxt = pix_wr_r ? hsfb_pkg::S_IDLE : hsfb_pkg::S_RESP;
      end
      hsfb_pkg::S_FSET: state_nxt = hsfb_pkg::S_FILL;
      hsfb_pkg::S_FILL: begin
        if (col_r == cr_r && rows_left_r == '0) state_nxt = hsfb_pkg::S_IDLE;
      end
      hsfb_pkg::S_RESP: begin
        if (rsp_free) state_nxt = hsfb_pkg::S_IDLE;
      end
      default: state_nxt = hsfb_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready  = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = '0;
    mem_wdata = cmd_r.color;
    rsp_load  = 1'b0;
    rsp       = '0;
    case (state_r)
      hsfb_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_addr_r;
        mem_wdata = '0;
      end
      hsfb_pkg::S_IDLE: in_ready = 1'b1;
      hsfb_pkg::S_EXEC: begin
        // read outside the active half answers zero without touching the store
        if (cmd_r.opcode == hsfb_pkg::OP_READ && !in_win && rsp_free) rsp_load = 1'b1;
      end
      hsfb_pkg::S_MEM: begin
        mem_we   = pix_wr_r;
        mem_re   = !pix_wr_r;
        mem_addr = AW'(pix_x_r) + AW'(AW'(pix_ro_r) * AW'(SCREEN_WIDTH));
      end
      hsfb_pkg::S_FILL: begin
        mem_we   = 1'b1;
        mem_addr = rbase_r + AW'(col_r);
      end
      hsfb_pkg::S_RESP: begin
        rsp_load        = rsp_free;
        rsp.pixel_value = mem_rdata;
        rsp.inside_res  = 1'b1;
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= hsfb_pkg::S_CLEAR;
      clr_addr_r    <= '0;
      blit_open_r   <= 1'b0;
      blit_keyed_r  <= 1'b0;
      blit_left_r   <= '0;
      blit_bottom_r <= '0;
      cols_r        <= '0;
      rows_r        <= '0;
      src_col_r     <= '0;
      src_row_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == hsfb_pkg::S_CLEAR) clr_addr_r <= AW'(clr_addr_r + 1'b1);
      if (state_r == hsfb_pkg::S_EXEC && cmd_r.opcode == hsfb_pkg::OP_HDR) begin
        blit_left_r   <= cmd_r.x_pos;
        blit_bottom_r <= cmd_r.y_pos;
        cols_r        <= COLW'(cmd_r.width);
        rows_r        <= ROWW'(cmd_r.height);
        blit_keyed_r  <= cmd_r.keyed;
        src_col_r     <= '0;
        src_row_r     <= '0;
        blit_open_r   <= (w_s >= ONE_S) && (w_s <= SW_S) && (h_s >= ONE_S) && (h_s <= H2_S);
      end
      if (state_r == hsfb_pkg::S_EXEC && is_bpix && blit_open_r) begin
        // clipped or keyed pixels still advance the source position
        if (src_col_inc == cols_r) begin
          src_col_r <= '0;
          if (src_row_inc == rows_r) begin
            src_row_r   <= '0;
            blit_open_r <= 1'b0;
          end else begin
            src_row_r <= src_row_inc;
          end
        end else begin
          src_col_r <= src_col_inc;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state_r == hsfb_pkg::S_IDLE && in_valid) cmd_r <= in_req;
    if (state_r == hsfb_pkg::S_EXEC) begin
      pix_x_r  <= px_s[CW-1:0];
      pix_ro_r <= ro_s[RW-1:0];
      pix_wr_r <= (cmd_r.opcode != hsfb_pkg::OP_READ);
      cl_r     <= cl_s[CW-1:0];
      cr_r     <= cr_s[CW-1:0];
      cto_r    <= ct_s[RW-1:0];
      cbo_r    <= cb_s[RW-1:0];
    end
    if (state_r == hsfb_pkg::S_FSET) begin
      rbase_r     <= AW'(AW'(ro_lo) * AW'(SCREEN_WIDTH));
      col_r       <= cl_r;
      rows_left_r <= RW'(cbo_r - cto_r);
    end
    if (state_r == hsfb_pkg::S_FILL) begin
      if (col_r == cr_r) begin
        col_r       <= cl_r;
        rbase_r     <= AW'(rbase_r + AW'(SCREEN_WIDTH));
        rows_left_r <= RW'(rows_left_r - 1'b1);
      end else begin
        col_r <= CW'(col_r + 1'b1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/half_screen_fill_blit_engine_top.sv
// ----------------------------------------------------------------------------
// half_screen_fill_blit_engine_top
// RGB565 half-screen framebuffer with set pixel, rectangle fill, color-key
// blit and pixel read-back.
// ----------------------------------------------------------------------------
//  channel | ports                              | moves
//  --------+------------------------------------+---------------------------
//  in      | in_valid, in_ready, in_req         | one command request
//  out     | out_valid, out_ready, out_rsp      | read-back pixel + inside
//  cfg     | cfg_valid, cfg_ready, cfg_half_select | active half select
//
//  Header, unused opcode, rejected fill, keyed-out pixel, or pixel or read off
//  the half: done in execute. Pixel write: one store write. Read in the half:
//  a store read. Any read waits while out holds an untaken result. Fill: one
//  write per clipped pixel. After reset all SCREEN_WIDTH*HALF_HEIGHT words
//  (8192 default) are zeroed, in_ready low; cfg writes are taken throughout.
//  A finished read waits in the out register while the next request enters.
// ----------------------------------------------------------------------------
`default_nettype none

module half_screen_fill_blit_engine_top #(
  parameter int SCREEN_WIDTH = hsfb_pkg::SCREEN_WIDTH,
  parameter int HALF_HEIGHT  = hsfb_pkg::HALF_HEIGHT
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire hsfb_pkg::in_req_t  in_req,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output hsfb_pkg::out_rsp_t      out_rsp,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_half_select
);

  localparam int DEPTH = SCREEN_WIDTH * HALF_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  logic                          half_sel_r;
  logic                          out_valid_r;
  hsfb_pkg::out_rsp_t            out_rsp_r;

  logic                          mem_we, mem_re;
  logic [AW-1:0]                 mem_addr;
  logic [hsfb_pkg::PIX_W-1:0]    mem_wdata, mem_rdata;
  logic                          rsp_free, rsp_load;
  hsfb_pkg::out_rsp_t            rsp;

  // config register: always ready; user writes it only while engine is quiet, unchecked
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_sel_r <= 1'b0;
    end else if (cfg_valid) begin
      half_sel_r <= cfg_half_select;
    end
  end

  // result register: loaded only when empty or draining this cycle
  assign rsp_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rsp_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) out_rsp_r <= rsp;
  end

  hsfb_engine #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .HALF_HEIGHT  (HALF_HEIGHT)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .half_sel  (half_sel_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .mem_we    (mem_we),
    .mem_re    (mem_re),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata),
    .rsp_free  (rsp_free),
    .rsp_load  (rsp_load),
    .rsp       (rsp)
  );

  // frame store, storage row = last row of the half minus screen row
  hsfb_ram #(
    .WIDTH (hsfb_pkg::PIX_W),
    .DEPTH (DEPTH)
  ) u_frame_store (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the half-screen fill/blit engine: a directed table
// followed by constrained-by-hand random requests, each read-back compared to
// a typed-in value or an in-bench framebuffer model, random idling both sides.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import hsfb_pkg::*;

  // Worst single request is a fill over the whole half.
  localparam int SETTLE_CYCLES = SCREEN_WIDTH * HALF_HEIGHT + 64;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int RANDOM_ITEMS  = 650;
  localparam int PHASES        = 4;
  localparam int BIG_FILLS     = 3;

  logic     clk             = 1'b0;
  logic     rst_n           = 1'b0;
  logic     in_valid        = 1'b0;
  logic     in_ready;
  in_req_t  in_req          = '0;
  logic     out_valid;
  logic     out_ready       = 1'b0;
  out_rsp_t out_rsp;
  logic     cfg_valid       = 1'b0;
  logic     cfg_ready;
  logic     cfg_half_select = 1'b0;

  half_screen_fill_blit_engine_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req          (in_req),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_rsp         (out_rsp),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_half_select (cfg_half_select)
  );

  // Directed row: the request, and where the answer is obvious, the read-back
  // typed in by hand instead of taken from the framebuffer model.
  typedef struct packed {
    in_req_t  req;
    logic     fixed;
    out_rsp_t want;
  } dir_row_t;

  // ---------------------------------------------------------------------------
  // Framebuffer model state
  // ---------------------------------------------------------------------------
  logic [PIX_W-1:0] pix_mem [SCREEN_WIDTH * HALF_HEIGHT];
  bit               lower_half;      // mirrors the half-select register
  int               bl_x, bl_y;      // blit bottom-left corner
  int               bl_w, bl_h;      // blit size
  int               bl_col, bl_row;  // next source pixel position
  bit               bl_active;
  bit               bl_skip_white;   // keyed blit: 0xFFFF source pixels skipped

  out_rsp_t readback_q[$];           // read-backs still owed by the engine
  int       items_done = 0;
  int       fails      = 0;
  bit       idling     = 1'b1;       // random idling on both channels

  // ---------------------------------------------------------------------------
  // Clock, receiver back-pressure, cycle limit
  // ---------------------------------------------------------------------------
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= !(idling && $urandom_range(0, 99) < 16);
  end

  int unsigned cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Read-back checker. Sampled at the falling edge, where both sides of the
  // handshake are settled; a high valid/ready pair here means the response is
  // taken at the next rising edge.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    out_rsp_t want;
    if (rst_n && out_valid && out_ready) begin
      if (readback_q.size() == 0) begin
        $error("read-back with nothing outstanding: pixel_value %h inside_res %b",
               out_rsp.pixel_value, out_rsp.inside_res);
        fails++;
      end else begin
        want = readback_q.pop_front();
        if (out_rsp.pixel_value !== want.pixel_value) begin
          $error("pixel_value: expected %h, got %h", want.pixel_value, out_rsp.pixel_value);
          fails++;
        end
        if (out_rsp.inside_res !== want.inside_res) begin
          $error("inside_res: expected %b, got %b", want.inside_res, out_rsp.inside_res);
          fails++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Model helpers
  // ---------------------------------------------------------------------------
  function automatic bit in_active_half(input int x, input int y);
    int first;
    first = lower_half ? HALF_HEIGHT : 0;
    return x >= 0 && x < SCREEN_WIDTH && y >= first && y < first + HALF_HEIGHT;
  endfunction

  // Rows are stored upside down: the last row of the half sits at index 0.
  function automatic int mem_index(input int x, input int y);
    int first;
    first = lower_half ? HALF_HEIGHT : 0;
    return (first + HALF_HEIGHT - 1 - y) * SCREEN_WIDTH + x;
  endfunction

  // Applies one accepted request to the model; reads return their response.
  function automatic void apply_command(input in_req_t r, output bit has_rsp,
                                        output out_rsp_t rsp);
    int x, y, w, h;
    int left, right, top, bot, first, last, sx, sy;
    x     = $signed(r.x_pos);
    y     = $signed(r.y_pos);
    w     = $signed(r.width);
    h     = $signed(r.height);
    first = lower_half ? HALF_HEIGHT : 0;
    last  = first + HALF_HEIGHT - 1;
    has_rsp = 1'b0;
    rsp     = '0;
    case (r.opcode)
      OP_SET: begin
        if (in_active_half(x, y)) pix_mem[mem_index(x, y)] = r.color;
      end
      OP_FILL: begin
        // exact 32-bit sums, so no 16-bit wrap on the far edges
        left  = x;
        right = x + w - 1;
        top   = y;
        bot   = y + h - 1;
        if (w <= SCREEN_WIDTH && h <= 2 * HALF_HEIGHT && left < SCREEN_WIDTH &&
            right >= 0 && bot >= first && top <= last) begin
          if (left < 0) left = 0;
          if (right > SCREEN_WIDTH - 1) right = SCREEN_WIDTH - 1;
          if (top < first) top = first;
          if (bot > last) bot = last;
          for (int row = top; row <= bot; row++)
            for (int col = left; col <= right; col++)
              pix_mem[mem_index(col, row)] = r.color;
        end
      end
      OP_HDR: begin
        bl_x          = x;
        bl_y          = y;
        bl_w          = w;
        bl_h          = h;
        bl_skip_white = r.keyed;
        bl_col        = 0;
        bl_row        = 0;
        bl_active     = w >= 1 && w <= SCREEN_WIDTH && h >= 1 && h <= 2 * HALF_HEIGHT;
      end
      OP_BPIX: begin
        if (bl_active) begin
          sx = bl_x + bl_col;
          sy = bl_y - bl_row;   // source rows climb up the screen
          if (in_active_half(sx, sy) && !(bl_skip_white && r.color == KEY_COLOR))
            pix_mem[mem_index(sx, sy)] = r.color;
          bl_col++;
          if (bl_col >= bl_w) begin
            bl_col = 0;
            bl_row++;
            if (bl_row >= bl_h) begin
              bl_row    = 0;
              bl_active = 1'b0;
            end
          end
        end
      end
      OP_READ: begin
        has_rsp = 1'b1;
        if (in_active_half(x, y)) begin
          rsp.pixel_value = pix_mem[mem_index(x, y)];
          rsp.inside_res  = 1'b1;
        end
      end
      default: ;   // unused opcodes do nothing
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic in_req_t make_req(input logic [2:0] op, input int x, input int y,
                                       input int w, input int h, input int c,
                                       input bit k);
    in_req_t r;
    r.opcode = op;
    r.x_pos  = x[15:0];
    r.y_pos  = y[15:0];
    r.width  = w[15:0];
    r.height = h[15:0];
    r.color  = c[15:0];
    r.keyed  = k;
    return r;
  endfunction

  // Columns a few pixels past either edge.
  function automatic int near_col();
    return int'($urandom_range(0, SCREEN_WIDTH + 7)) - 4;
  endfunction

  // Rows around the active half mostly, sometimes around the other one.
  function automatic int near_row();
    bit lower;
    lower = ($urandom_range(0, 4) == 0) ? !lower_half : lower_half;
    return (lower ? HALF_HEIGHT : 0) + int'($urandom_range(0, HALF_HEIGHT + 7)) - 4;
  endfunction

  // A size the engine must turn down.
  function automatic int bad_size();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return -1;
      2:       return 2 * HALF_HEIGHT + 1;
      default: return -32768;
    endcase
  endfunction

  // Random one-bit field.
  function automatic bit rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  // Drives one request, holds it until the engine takes it, then books it in
  // the model. A directed row may carry its own read-back value.
  task automatic send_request(input in_req_t r, input bit fixed = 1'b0,
                              input out_rsp_t want = '0);
    bit       took;
    bit       has_rsp;
    bit       counts;
    out_rsp_t rsp;
    while (idling && $urandom_range(0, 99) < 16) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
    // stray blit pixels and unused opcodes do not count as work
    counts = r.opcode <= OP_READ && !(r.opcode == OP_BPIX && !bl_active);
    apply_command(r, has_rsp, rsp);
    if (has_rsp) readback_q.push_back(fixed ? want : rsp);
    if (counts) items_done++;
  endtask

  // Sender holds off until every read-back is in; with settle it also waits
  // out a fill that may still be running, since fills answer nothing.
  task automatic wait_for_readbacks(input bit settle);
    in_valid <= 1'b0;
    while (readback_q.size() != 0) @(posedge clk);
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_half_select(input bit half);
    bit took;
    cfg_valid       <= 1'b1;
    cfg_half_select <= half;
    do begin
      @(negedge clk);
      took = cfg_ready;
      @(posedge clk);
    end while (!took);
    cfg_valid  <= 1'b0;
    lower_half = half;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  dir_row_t dir_tab[$];

  initial begin
    int kind, w, h, n, phase, phase_end, big_left;
    foreach (pix_mem[i]) pix_mem[i] = '0;
    lower_half    = 1'b0;
    bl_x          = 0;
    bl_y          = 0;
    bl_w          = 0;
    bl_h          = 0;
    bl_col        = 0;
    bl_row        = 0;
    bl_active     = 1'b0;
    bl_skip_white = 1'b0;
    big_left      = BIG_FILLS;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    // cfg is taken while the store is still being swept
    write_half_select(1'b0);

    // Directed table, upper half active, store freshly cleared.
    dir_tab.push_back('{make_req(OP_READ, 0, 0, 0, 0, 0, 0), 1'b1, {16'h0000, 1'b1}});
    dir_tab.push_back('{make_req(OP_READ, -32768, 0, 0, 0, 0, 0), 1'b1, {16'h0000, 1'b0}});
    dir_tab.push_back('{make_req(OP_READ, 127, 32767, 0, 0, 0, 0), 1'b1, {16'h0000, 1'b0}});
    dir_tab.push_back('{make_req(OP_READ, 0, 64, 0, 0, 0, 0), 1'b1, {16'h0000, 1'b0}});
    dir_tab.push_back('{make_req(OP_SET, 0, 0, 0, 0, 16'hFFFF, 0), 1'b0, '0});
    dir_tab.push_back('{make_req(OP_READ, 0, 0, 0, 0, 0, 0), 1'b1, {16'hFFFF, 1'b1}});
    // set pixel one column past the right edge is dropped
    dir_tab.push_back('{make_req(OP_SET, 128, 5, 0, 0, 16'hAAAA, 0), 1'b0, '0});
    // full-screen fill clips to the whole half
    dir_tab.push_back('{make_req(OP_FILL, 0, 0, 128, 128, 16'h8000, 0), 1'b0, '0});
    dir_tab.push_back('{make_req(OP_READ, 127, 63, 0, 0, 0, 0), 1'b1, {16'h8000, 1'b1}});
    // clipped on the left and below the half
    dir_tab.push_back('{make_req(OP_FILL, -4, 60, 16, 16, 16'h7BEF, 0), 1'b0, '0});
    // rejected fills: too wide, empty, extreme size, wholly outside
    dir_tab.push_back('{make_req(OP_FILL, 0, 0, 129, 4, 16'hFFFF, 0), 1'b0, '0});
    dir_tab.push_back('{make_req(OP_FILL, 0, 0, 4, 0, 16'hFFFF, 0), 1'b0, '0});
    dir_tab.push_back('{make_req(OP_FILL, -32768, -32768, 32767, 32767, 16'hFFFF, 1),
                        1'b0, '0});
    dir_tab.push_back('{make_req(OP_FILL, 0, 64, 8, 8, 16'hFFFF, 0), 1'b0, '0});
    dir_tab.push_back('{make_req(OP_READ, 0, 63, 0, 0, 0, 0), 1'b0, '0});
    // opaque blit at the right edge, straddling the top of the screen
    dir_tab.push_back('{make_req(OP_HDR, 126, 0, 2, 2, 0, 0), 1'b0, '0});
    dir_tab.push_back('{make_req(OP_BPIX, 0, 0, 0, 0, 16'h1111, 0), 1'b0, '0});
    dir_tab.push_back('{make_req(OP_BPIX, 0, 0, 0, 0, 16'hFFFF, 0), 1'b0, '0});
    dir_tab.push_back('{make_req(OP_BPIX, 0, 0, 0, 0, 16'h3333, 0), 1'b0, '0});
    dir_tab.push_back('{make_req(OP_BPIX, 0, 0, 0, 0, 16'h4444, 0), 1'b0, '0});
    // keyed blit: the white pixel leaves the fill color in place
    dir_tab.push_back('{make_req(OP_HDR, 10, 10, 2, 1, 0, 1), 1'b0, '0});
    dir_tab.push_back('{make_req(OP_BPIX, 0, 0, 0, 0, 16'hFFFF, 0), 1'b0, '0});
    dir_tab.push_back('{make_req(OP_BPIX, 0, 0, 0, 0, 16'h1234, 0), 1'b0, '0});
    // blit already closed, pixel ignored
    dir_tab.push_back('{make_req(OP_BPIX, 0, 0, 0, 0, 16'h5555, 0), 1'b0, '0});
    dir_tab.push_back('{make_req(OP_READ, 10, 10, 0, 0, 0, 0), 1'b0, '0});
    dir_tab.push_back('{make_req(OP_READ, 127, 0, 0, 0, 0, 0), 1'b0, '0});
    dir_tab.push_back('{make_req(3'd7, 1, 1, 1, 1, 16'hFFFF, 1), 1'b0, '0});

    foreach (dir_tab[i]) send_request(dir_tab[i].req, dir_tab[i].fixed, dir_tab[i].want);
    wait_for_readbacks(1'b1);

    // Random phases alternate the half; phase 1 runs with no idling at all.
    for (phase = 0; phase < PHASES; phase++) begin
      write_half_select(~phase[0]);
      idling    = (phase != 1);
      phase_end = items_done + RANDOM_ITEMS / PHASES;
      while (items_done < phase_end) begin
        // now and then the sender waits for every read-back to land
        if ($urandom_range(0, 99) == 0) wait_for_readbacks(1'b0);
        kind = $urandom_range(0, 99);
        if (kind < 22) begin
          send_request(make_req(OP_SET, near_col(), near_row(), $urandom, $urandom,
                                $urandom, rand_bit()));
        end else if (kind < 47) begin
          send_request(make_req(OP_READ, near_col(), near_row(), $urandom, $urandom,
                                $urandom, rand_bit()));
        end else if (kind < 59) begin
          // mostly small fills; a few near full size, some invalid
          if (big_left > 0 && $urandom_range(0, 39) == 0) begin
            w = $urandom_range(64, SCREEN_WIDTH);
            h = $urandom_range(32, 2 * HALF_HEIGHT);
            big_left--;
          end else begin
            w = $urandom_range(1, 8);
            h = $urandom_range(1, 8);
            if ($urandom_range(0, 9) == 0) begin
              if ($urandom_range(0, 1)) w = bad_size();
              else h = bad_size();
            end
          end
          send_request(make_req(OP_FILL, near_col(), near_row(), w, h, $urandom,
                                rand_bit()));
        end else if (kind < 84) begin
          // well-formed blit; sometimes cut short by the next header
          w = $urandom_range(1, 6);
          h = $urandom_range(1, 4);
          send_request(make_req(OP_HDR, near_col(), near_row(), w, h, $urandom,
                                rand_bit()));
          n = w * h;
          if ($urandom_range(0, 9) == 0) n = $urandom_range(0, n - 1);
          for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 19) == 0)
              send_request(make_req(OP_READ, near_col(), near_row(), 0, 0, 0, 0));
            send_request(make_req(OP_BPIX, $urandom, $urandom, $urandom, $urandom,
                                  ($urandom_range(0, 3) == 0) ? 16'hFFFF : $urandom,
                                  rand_bit()));
          end
        end else if (kind < 94) begin
          // noise: every field fully random, unused opcodes included
          send_request(make_req(3'($urandom_range(0, 7)), $urandom, $urandom, $urandom,
                                $urandom, $urandom, rand_bit()));
        end else begin
          // rejected header, then pixels that must be ignored
          w = $urandom_range(1, 4);
          h = $urandom_range(1, 4);
          if ($urandom_range(0, 1)) w = bad_size();
          else h = bad_size();
          send_request(make_req(OP_HDR, near_col(), near_row(), w, h, $urandom,
                                rand_bit()));
          n = $urandom_range(1, 3);
          for (int k = 0; k < n; k++)
            send_request(make_req(OP_BPIX, 0, 0, 0, 0, $urandom, 0));
        end
      end
      wait_for_readbacks(1'b1);
    end

    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
